// ===== sv/uifb_pkg.sv =====
`default_nettype none

package uifb_pkg;

  // Frame layout
  localparam int HDR_BYTES     = 42;
  localparam int HDR_IDX_W     = $clog2(HDR_BYTES);
  localparam int LEN_W         = 13;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 48;
  localparam int MAX_PAYLOAD_DEFAULT = 8000;

  // Fixed header lengths added to the payload length
  localparam logic [15:0] IP_UDP_HDR_BYTES = 16'd28;
  localparam logic [15:0] UDP_HDR_BYTES    = 16'd8;

  // Fixed header words
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_DSCP       = 8'h00;
  localparam logic [15:0] IP_ID         = 16'hABCD;
  localparam logic [15:0] IP_FLAGS_DF   = 16'h4000;
  localparam logic [7:0]  IP_TTL        = 8'h40;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'h11;
  localparam logic [15:0] UDP_CSUM_NONE = 16'h0000;

  // Sum of the constant IPv4 header words, as the checksum sees them
  localparam logic [19:0] CSUM_CONST_SUM = 20'({IP_VER_IHL, IP_DSCP}) + 20'(IP_ID)
                                         + 20'(IP_FLAGS_DF) + 20'({IP_TTL, IP_PROTO_UDP});

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_MAC    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_IP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PORT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_PORT   = 3'd5;

  // Input operations
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  typedef struct packed {
    logic             op;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       run_end;
    logic       frame_end;
  } out_item_t;

  // Everything the header byte select needs
  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] ip_len;
    logic [15:0] ip_csum;
    logic [15:0] udp_len;
  } hdr_t;

endpackage

`default_nettype wire

// ===== sv/uifb_hdr_mux.sv =====
`default_nettype none

module uifb_hdr_mux (
  input  uifb_pkg::hdr_t                     hdr,
  input  logic [uifb_pkg::HDR_IDX_W-1:0]     idx,
  output logic [7:0]                         frame_byte
);
  import uifb_pkg::*;

  logic [HDR_BYTES-1:0][7:0] hdr_bytes;
  logic [HDR_IDX_W-1:0]      rev;

  // Header in wire order, first byte in the top lane.
  assign hdr_bytes = {hdr.dest_mac, hdr.source_mac, ETH_TYPE_IPV4,
                      IP_VER_IHL, IP_DSCP, hdr.ip_len, IP_ID, IP_FLAGS_DF,
                      IP_TTL, IP_PROTO_UDP, hdr.ip_csum, hdr.source_ip, hdr.dest_ip,
                      hdr.source_port, hdr.dest_port, hdr.udp_len, UDP_CSUM_NONE};

  // Byte offset counts from the top lane down.
  assign rev        = HDR_IDX_W'(HDR_BYTES - 1) - idx;
  assign frame_byte = hdr_bytes[rev];

endmodule

`default_nettype wire

// ===== sv/udp_ipv4_frame_builder_top.sv =====
`default_nettype none
// Ethernet/IPv4/UDP transmit frame builder, one frame byte per output beat.
// Input channel (in_valid/in_ready/in_item): a start beat carries the payload
// length and makes the 42 header bytes; each payload beat carries one byte that
// is passed through. The last byte of a frame carries frame_end, and the last
// byte caused by an input beat carries run_end. Payload beats with no frame
// open are consumed and dropped. Lengths above MAX_PAYLOAD are clipped.
// Addresses and ports are set through the write port (cfg_wr_en, cfg_addr,
// cfg_data); the user must write them only while the block is idle, which the
// block does not enforce. Unknown indexes are ignored. An accepted input beat
// waits in the input register before its first output byte is loaded into the
// output register. Payload beats flow at one per cycle while the receiver keeps
// up and no header burst runs; a start beat holds the output for all 42 header
// bytes, walked by the header counter one byte per cycle as the receiver takes
// them, while the beat behind it waits in the input register. Reset clears the
// configuration and frame state to zero, closes any open frame and empties both
// the input and output registers. When the receiver stalls, the output byte holds,
// the header counter stops, and in_ready drops once the input register is full.
module udp_ipv4_frame_builder_top #(
  parameter int MAX_PAYLOAD = uifb_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [uifb_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [uifb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  uifb_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output uifb_pkg::out_item_t                  out_item
);
  import uifb_pkg::*;

  // Configuration registers
  logic [47:0] source_mac;
  logic [47:0] dest_mac;
  logic [31:0] source_ip;
  logic [31:0] dest_ip;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [19:0] cfg_sum;

  // Input register
  logic             a_valid;
  logic             a_op;
  logic [LEN_W-1:0] a_len;
  logic [7:0]       a_byte;
  logic [LEN_W-1:0] len_sat;

  // Frame state and header burst
  logic                 frame_open;
  logic [LEN_W-1:0]     bytes_left;
  logic [LEN_W-1:0]     bytes_left_next;
  logic                 hdr_active;
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic [HDR_IDX_W-1:0] mux_idx;
  logic [15:0]          ip_len;
  logic [15:0]          udp_len;
  logic [15:0]          ip_csum;
  logic                 zero_len;
  hdr_t                 hdr;
  logic [7:0]           hdr_byte;

  // Header fields computed from the input register
  logic [15:0] ip_len_next;
  logic [15:0] udp_len_next;
  logic [19:0] csum_sum;
  logic [16:0] csum_fold1;
  logic [16:0] csum_fold2;

  logic adv;
  logic drop;
  logic a_take;
  logic hdr_last;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_mac  <= '0;
      dest_mac    <= '0;
      source_ip   <= '0;
      dest_ip     <= '0;
      source_port <= '0;
      dest_port   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SOURCE_MAC:  source_mac  <= cfg_data[47:0];
        REG_DEST_MAC:    dest_mac    <= cfg_data[47:0];
        REG_SOURCE_IP:   source_ip   <= cfg_data[31:0];
        REG_DEST_IP:     dest_ip     <= cfg_data[31:0];
        REG_SOURCE_PORT: source_port <= cfg_data[15:0];
        REG_DEST_PORT:   dest_port   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The part of the checksum that does not depend on the length is kept ready;
  // the user must change addresses only while the block is idle; it is not checked.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_sum <= CSUM_CONST_SUM;
    end else begin
      cfg_sum <= CSUM_CONST_SUM + 20'(source_ip[31:16]) + 20'(source_ip[15:0])
               + 20'(dest_ip[31:16]) + 20'(dest_ip[15:0]);
    end
  end

  // Clip the requested length on the way in.
  always_comb begin
    if ({4'b0, in_item.payload_length} > 17'(MAX_PAYLOAD)) begin
      len_sat = LEN_W'(MAX_PAYLOAD);
    end else begin
      len_sat = in_item.payload_length;
    end
  end

  // Header words and the IPv4 checksum with end-around carry folding.
  always_comb begin
    ip_len_next  = IP_UDP_HDR_BYTES + 16'(a_len);
    udp_len_next = UDP_HDR_BYTES + 16'(a_len);
    csum_sum     = cfg_sum + 20'(ip_len_next);
    csum_fold1   = 17'(csum_sum[15:0]) + 17'(csum_sum[19:16]);
    csum_fold2   = 17'(csum_fold1[15:0]) + 17'(csum_fold1[16]);
  end

  // Handshake: the header burst owns the output; a payload beat with no
  // open frame is taken without waiting for the output side.
  always_comb begin
    adv      = !out_valid || out_ready;
    drop     = a_valid && (a_op == OP_PAYLOAD) && !frame_open;
    a_take   = a_valid && !hdr_active && (drop || adv);
    in_ready = !a_valid || a_take;
    hdr_last = (hdr_idx == HDR_IDX_W'(HDR_BYTES - 1));
    mux_idx  = hdr_active ? hdr_idx : '0;
    bytes_left_next = bytes_left - LEN_W'(1);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_op   <= in_item.op;
      a_len  <= len_sat;
      a_byte <= in_item.payload_byte;
    end
  end

  // Header byte select.
  always_comb begin
    hdr.dest_mac    = dest_mac;
    hdr.source_mac  = source_mac;
    hdr.source_ip   = source_ip;
    hdr.dest_ip     = dest_ip;
    hdr.source_port = source_port;
    hdr.dest_port   = dest_port;
    hdr.ip_len      = ip_len;
    hdr.ip_csum     = ip_csum;
    hdr.udp_len     = udp_len;
  end

  uifb_hdr_mux u_hdr_mux (
    .hdr        (hdr),
    .idx        (mux_idx),
    .frame_byte (hdr_byte)
  );

  // Frame state, header counter and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= '0;
      hdr_active <= 1'b0;
      hdr_idx    <= '0;
      out_valid  <= 1'b0;
    end else if (hdr_active) begin
      if (adv) begin
        out_valid          <= 1'b1;
        out_item.frame_byte <= hdr_byte;
        out_item.run_end   <= hdr_last;
        out_item.frame_end <= hdr_last && zero_len;
        hdr_idx            <= hdr_idx + HDR_IDX_W'(1);
        if (hdr_last) begin
          hdr_active <= 1'b0;
        end
      end
    end else if (a_take && !drop) begin
      out_valid <= 1'b1;
      if (a_op == OP_START) begin
        // The first header byte leaves right away; the rest follow.
        out_item.frame_byte <= hdr_byte;
        out_item.run_end    <= 1'b0;
        out_item.frame_end  <= 1'b0;
        hdr_active <= 1'b1;
        hdr_idx    <= HDR_IDX_W'(1);
        ip_len     <= ip_len_next;
        udp_len    <= udp_len_next;
        ip_csum    <= ~csum_fold2[15:0];
        zero_len   <= (a_len == '0);
        bytes_left <= a_len;
        frame_open <= (a_len != '0);
      end else begin
        out_item.frame_byte <= a_byte;
        out_item.run_end    <= 1'b1;
        out_item.frame_end  <= (bytes_left_next == '0);
        bytes_left <= bytes_left_next;
        frame_open <= (bytes_left_next != '0);
      end
    end else if (adv) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
